// ===== hdl/etb_pkg.sv =====
// Shared types and constants for the event timer bank.
`default_nettype none
package etb_pkg;

  localparam int unsigned CountW     = 16;
  localparam int unsigned IndexW     = 3;
  localparam int unsigned CmdW       = 3;
  localparam int unsigned TimeW      = 29;
  localparam int unsigned RemW       = 4;
  // Wide enough to compare an index against any timer number below 128.
  localparam int unsigned SelW       = 7;

  localparam logic [CountW-1:0] ResetPeriod = 16'd1024;
  localparam logic [RemW-1:0]   TimeDivisor = 4'd10;
  // The tick counter 2^32-1 splits into this quotient and remainder by ten.
  localparam logic [TimeW-1:0]  WrapQuot    = 29'd429496729;
  localparam logic [RemW-1:0]   WrapRem     = 4'd5;

  typedef enum logic [CmdW-1:0] {
    CMD_TICK       = 3'd0,
    CMD_SET_PERIOD = 3'd1,
    CMD_READ_FLAG  = 3'd2,
    CMD_CLEAR_FLAG = 3'd3,
    CMD_TAKE_FLAG  = 3'd4,
    CMD_READ_TIME  = 3'd5
  } cmd_e;

  typedef struct packed {
    logic              tick;
    logic              set_period;
    logic              clear_flag;
    logic [IndexW-1:0] index;
    logic [CountW-1:0] period;
  } bank_ctrl_t;

endpackage
`default_nettype wire

// ===== hdl/etb_timer_bank.sv =====
// Bank of auto-reload down counters with their expired flags.
`default_nettype none
module etb_timer_bank #(
  parameter int unsigned TIMER_COUNT = 8
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire etb_pkg::bank_ctrl_t ctrl_i,
  output logic                     flag_o
);

  logic [etb_pkg::CountW-1:0] count_q  [TIMER_COUNT];
  logic [etb_pkg::CountW-1:0] count_d  [TIMER_COUNT];
  logic [etb_pkg::CountW-1:0] reload_q [TIMER_COUNT];
  logic [etb_pkg::CountW-1:0] reload_d [TIMER_COUNT];
  logic [TIMER_COUNT-1:0]     flag_q;
  logic [TIMER_COUNT-1:0]     flag_d;
  logic [TIMER_COUNT-1:0]     hit;

  // Timers past the index field's reach never match and are never addressed.
  always_comb begin
    for (int t = 0; t < TIMER_COUNT; t++) begin
      hit[t] = ({{(etb_pkg::SelW-etb_pkg::IndexW){1'b0}}, ctrl_i.index}
                == etb_pkg::SelW'(t));
    end
  end

  assign flag_o = |(flag_q & hit);

  always_comb begin
    for (int t = 0; t < TIMER_COUNT; t++) begin
      count_d[t]  = count_q[t];
      reload_d[t] = reload_q[t];
      flag_d[t]   = flag_q[t];
      if (ctrl_i.tick) begin
        if (count_q[t] != '0) begin
          count_d[t] = count_q[t] - etb_pkg::CountW'(1);
        end else begin
          count_d[t] = reload_q[t];
          flag_d[t]  = 1'b1;
        end
      end else if (ctrl_i.set_period && hit[t]) begin
        count_d[t]  = ctrl_i.period;
        reload_d[t] = ctrl_i.period;
        flag_d[t]   = 1'b0;
      end else if (ctrl_i.clear_flag && hit[t]) begin
        flag_d[t] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int t = 0; t < TIMER_COUNT; t++) begin
        count_q[t]  <= etb_pkg::ResetPeriod;
        reload_q[t] <= etb_pkg::ResetPeriod;
      end
      flag_q <= '0;
    end else begin
      count_q  <= count_d;
      reload_q <= reload_d;
      flag_q   <= flag_d;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/etb_time_base.sv =====
// System tick counter kept directly as quotient and remainder by ten.
`default_nettype none
module etb_time_base (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      tick_i,
  output logic [etb_pkg::TimeW-1:0]      time_o
);

  logic [etb_pkg::TimeW-1:0] quot_q, quot_d;
  logic [etb_pkg::RemW-1:0]  rem_q, rem_d;

  always_comb begin
    quot_d = quot_q;
    rem_d  = rem_q;
    if (tick_i) begin
      // The full 32-bit count wraps to zero after its largest value.
      priority if (quot_q == etb_pkg::WrapQuot && rem_q == etb_pkg::WrapRem) begin
        quot_d = '0;
        rem_d  = '0;
      end else if (rem_q == etb_pkg::TimeDivisor - etb_pkg::RemW'(1)) begin
        quot_d = quot_q + etb_pkg::TimeW'(1);
        rem_d  = '0;
      end else begin
        rem_d = rem_q + etb_pkg::RemW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quot_q <= '0;
      rem_q  <= '0;
    end else begin
      quot_q <= quot_d;
      rem_q  <= rem_d;
    end
  end

  assign time_o = quot_q;

endmodule
`default_nettype wire

// ===== hdl/event_timer_bank_top.sv =====
// Top level of the event timer bank: input register, command decode, result register.
//
// One input word carries a command, a timer index and a period. Every accepted
// word yields exactly one result word with the addressed flag (as it was before
// the command) and the time in ticks divided by ten; fields that a command does
// not produce read zero.
// Both channels use valid and stall; a word moves on an edge with valid high and
// stall low. An accepted word is held in the input register, is executed
// against the timer state as it leaves, and its result is loaded into the output
// register at that same edge, from which it is offered to the receiver.
// One word per cycle is sustained unless the receiver stalls; the timer bank
// updates all counters together; the time base keeps a running quotient by ten.
// While the receiver stalls, the result holds and one more word can wait in the
// input register; after that in_stall_o rises until the result is taken.
// Reset loads every count and period with 1024, clears all flags and the tick
// count, and empties both registers.
`default_nettype none
module event_timer_bank_top #(
  parameter int unsigned TIMER_COUNT = 8
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_stall_o,
  input  wire logic [etb_pkg::CmdW-1:0]     command_i,
  input  wire logic [etb_pkg::IndexW-1:0]   timer_index_i,
  input  wire logic [etb_pkg::CountW-1:0]   period_value_i,
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output logic                              flag_value_o,
  output logic [etb_pkg::TimeW-1:0]         time_value_o
);

  logic                        s1_valid_q, s1_valid_d;
  logic [etb_pkg::CmdW-1:0]    s1_cmd_q;
  logic [etb_pkg::IndexW-1:0]  s1_idx_q;
  logic [etb_pkg::CountW-1:0]  s1_period_q;
  logic                        out_valid_q, out_valid_d;
  logic                        flag_q, flag_d;
  logic [etb_pkg::TimeW-1:0]   time_q, time_d;

  logic                        advance;
  logic                        accept;
  logic                        fire;
  etb_pkg::cmd_e               cmd;
  etb_pkg::bank_ctrl_t         ctrl;
  logic                        bank_flag;
  logic [etb_pkg::TimeW-1:0]   now;

  assign advance    = !out_valid_q || !out_stall_i;
  assign in_stall_o = s1_valid_q && !advance;
  assign accept     = in_valid_i && !in_stall_o;
  assign fire       = s1_valid_q && advance;
  assign cmd        = etb_pkg::cmd_e'(s1_cmd_q);

  always_comb begin
    ctrl        = '0;
    ctrl.index  = s1_idx_q;
    ctrl.period = s1_period_q;
    flag_d      = 1'b0;
    time_d      = '0;
    unique case (cmd)
      etb_pkg::CMD_TICK: begin
        ctrl.tick = fire;
      end
      etb_pkg::CMD_SET_PERIOD: begin
        ctrl.set_period = fire;
      end
      etb_pkg::CMD_READ_FLAG: begin
        flag_d = bank_flag;
      end
      etb_pkg::CMD_CLEAR_FLAG, etb_pkg::CMD_TAKE_FLAG: begin
        ctrl.clear_flag = fire;
        flag_d          = bank_flag;
      end
      etb_pkg::CMD_READ_TIME: begin
        time_d = now;
      end
      default: begin
      end
    endcase
  end

  etb_timer_bank #(
    .TIMER_COUNT(TIMER_COUNT)
  ) u_bank (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .ctrl_i(ctrl),
    .flag_o(bank_flag)
  );

  etb_time_base u_time (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .tick_i(ctrl.tick),
    .time_o(now)
  );

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (accept) begin
      s1_valid_d = 1'b1;
    end else if (advance) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = advance ? s1_valid_q : out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_cmd_q    <= command_i;
      s1_idx_q    <= timer_index_i;
      s1_period_q <= period_value_i;
    end
    if (fire) begin
      flag_q <= flag_d;
      time_q <= time_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign flag_value_o = flag_q;
  assign time_value_o = time_q;

  // A stall toward the sender only ever holds back a waiting word.
  a_stall_has_word : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_valid_q)
    else $error("input stalled with an empty input register");

  // Only a time read may carry a nonzero time into the result register.
  a_time_only_on_read : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && cmd != etb_pkg::CMD_READ_TIME) |=> (time_value_o == '0))
    else $error("time field nonzero for a command other than read time");

  // Tick and set period answer with a clear flag.
  a_flag_zero_on_update : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && (cmd == etb_pkg::CMD_TICK || cmd == etb_pkg::CMD_SET_PERIOD))
    |=> !flag_value_o)
    else $error("flag field set for tick or set period");

  // Executing a word always leaves a result offered in the next cycle.
  a_fire_gives_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> out_valid_o)
    else $error("executed word produced no result");

endmodule
`default_nettype wire

// ===== test/event_timer_bank_top_tb.sv =====
// Self-checking testbench for the event timer bank: a directed table, then random words.
`default_nettype none
module event_timer_bank_top_tb;

  localparam int unsigned BankSize    = 8;
  localparam int unsigned DirectedLen = 25;
  localparam int unsigned RandomLen   = 1225;
  localparam int unsigned QuietLen    = 150;
  localparam int unsigned StallLimit  = 1000;
  localparam int unsigned DrainCycles = 8;

  // Command codes that the block decodes to no operation.
  localparam logic [etb_pkg::CmdW-1:0] CMD_SPARE_LO = 3'd6;
  localparam logic [etb_pkg::CmdW-1:0] CMD_SPARE_HI = 3'd7;

  typedef struct packed {
    logic [etb_pkg::CmdW-1:0]   cmd;
    logic [etb_pkg::IndexW-1:0] idx;
    logic [etb_pkg::CountW-1:0] period;
    logic                       known;
    logic                       flag;
    logic [etb_pkg::TimeW-1:0]  ticks_div;
  } directed_row_t;

  typedef struct packed {
    logic                      flag;
    logic [etb_pkg::TimeW-1:0] ticks_div;
  } timer_result_t;

  // Known results are typed in; the rest come from the predictor.
  localparam directed_row_t DirectedRows [DirectedLen] = '{
    '{etb_pkg::CMD_READ_FLAG,  3'd0, 16'h0000, 1'b1, 1'b0, 29'd0},
    '{etb_pkg::CMD_READ_TIME,  3'd0, 16'h0000, 1'b1, 1'b0, 29'd0},
    '{etb_pkg::CMD_TAKE_FLAG,  3'd7, 16'h0000, 1'b1, 1'b0, 29'd0},
    '{etb_pkg::CMD_CLEAR_FLAG, 3'd3, 16'h0000, 1'b1, 1'b0, 29'd0},
    '{CMD_SPARE_LO,            3'd5, 16'hFFFF, 1'b1, 1'b0, 29'd0},
    '{CMD_SPARE_HI,            3'd7, 16'hFFFF, 1'b1, 1'b0, 29'd0},
    '{etb_pkg::CMD_SET_PERIOD, 3'd0, 16'h0000, 1'b1, 1'b0, 29'd0},
    '{etb_pkg::CMD_SET_PERIOD, 3'd7, 16'hFFFF, 1'b1, 1'b0, 29'd0},
    '{etb_pkg::CMD_SET_PERIOD, 3'd3, 16'h0001, 1'b1, 1'b0, 29'd0},
    '{etb_pkg::CMD_TICK,       3'd0, 16'h0000, 1'b1, 1'b0, 29'd0},
    '{etb_pkg::CMD_READ_FLAG,  3'd0, 16'h0000, 1'b1, 1'b1, 29'd0},
    '{etb_pkg::CMD_TICK,       3'd4, 16'h1234, 1'b0, 1'b0, 29'd0},
    '{etb_pkg::CMD_TICK,       3'd2, 16'h0000, 1'b0, 1'b0, 29'd0},
    '{etb_pkg::CMD_TAKE_FLAG,  3'd3, 16'h0000, 1'b0, 1'b0, 29'd0},
    '{etb_pkg::CMD_TAKE_FLAG,  3'd3, 16'h0000, 1'b0, 1'b0, 29'd0},
    '{etb_pkg::CMD_CLEAR_FLAG, 3'd0, 16'h0000, 1'b0, 1'b0, 29'd0},
    '{etb_pkg::CMD_READ_FLAG,  3'd0, 16'h0000, 1'b0, 1'b0, 29'd0},
    '{etb_pkg::CMD_READ_FLAG,  3'd7, 16'h0000, 1'b0, 1'b0, 29'd0},
    '{etb_pkg::CMD_SET_PERIOD, 3'd5, 16'h5555, 1'b0, 1'b0, 29'd0},
    '{etb_pkg::CMD_SET_PERIOD, 3'd6, 16'hAAAA, 1'b0, 1'b0, 29'd0},
    '{etb_pkg::CMD_TICK,       3'd1, 16'h0000, 1'b0, 1'b0, 29'd0},
    '{etb_pkg::CMD_READ_TIME,  3'd6, 16'h0000, 1'b0, 1'b0, 29'd0},
    '{etb_pkg::CMD_READ_FLAG,  3'd1, 16'h0000, 1'b0, 1'b0, 29'd0},
    '{etb_pkg::CMD_SET_PERIOD, 3'd2, 16'h0002, 1'b0, 1'b0, 29'd0},
    '{etb_pkg::CMD_READ_FLAG,  3'd2, 16'h0000, 1'b1, 1'b0, 29'd0}
  };

  logic                       clk_i;
  logic                       rst_ni;
  logic                       in_valid_i;
  logic                       in_stall_o;
  logic [etb_pkg::CmdW-1:0]   command_i;
  logic [etb_pkg::IndexW-1:0] timer_index_i;
  logic [etb_pkg::CountW-1:0] period_value_i;
  logic                       out_valid_o;
  logic                       out_stall_i;
  logic                       flag_value_o;
  logic [etb_pkg::TimeW-1:0]  time_value_o;

  // Predictor state.
  logic [etb_pkg::CountW-1:0] count_model  [BankSize];
  logic [etb_pkg::CountW-1:0] reload_model [BankSize];
  logic                       flag_model   [BankSize];
  logic [31:0]                tick_model;

  timer_result_t expected_results [$];
  int unsigned   mismatches;
  int unsigned   words_sent;
  int unsigned   results_checked;
  int unsigned   flags_seen;
  bit            quiet;

  event_timer_bank_top #(
    .TIMER_COUNT(BankSize)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .command_i     (command_i),
    .timer_index_i (timer_index_i),
    .period_value_i(period_value_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .flag_value_o  (flag_value_o),
    .time_value_o  (time_value_o)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  function automatic void reset_timer_model();
    for (int t = 0; t < BankSize; t++) begin
      count_model[t]  = etb_pkg::ResetPeriod;
      reload_model[t] = etb_pkg::ResetPeriod;
      flag_model[t]   = 1'b0;
    end
    tick_model = '0;
  endfunction

  // Applies one command to the timer state and returns the word it answers with.
  function automatic timer_result_t timer_bank_predict(logic [etb_pkg::CmdW-1:0] cmd,
                                                       logic [etb_pkg::IndexW-1:0] idx,
                                                       logic [etb_pkg::CountW-1:0] period);
    timer_result_t res;
    bit            in_bank;
    res     = '0;
    in_bank = (int'(idx) < BankSize);
    case (cmd)
      etb_pkg::CMD_TICK: begin
        for (int t = 0; t < BankSize; t++) begin
          if (count_model[t] != '0) begin
            count_model[t] = count_model[t] - 1'b1;
          end else begin
            count_model[t] = reload_model[t];
            flag_model[t]  = 1'b1;
          end
        end
        tick_model = tick_model + 1;
      end
      etb_pkg::CMD_SET_PERIOD: begin
        if (in_bank) begin
          count_model[idx]  = period;
          reload_model[idx] = period;
          flag_model[idx]   = 1'b0;
        end
      end
      etb_pkg::CMD_READ_FLAG: begin
        if (in_bank) res.flag = flag_model[idx];
      end
      etb_pkg::CMD_CLEAR_FLAG, etb_pkg::CMD_TAKE_FLAG: begin
        if (in_bank) begin
          res.flag        = flag_model[idx];
          flag_model[idx] = 1'b0;
        end
      end
      etb_pkg::CMD_READ_TIME: begin
        res.ticks_div = etb_pkg::TimeW'(tick_model / 32'd10);
      end
      default: begin
      end
    endcase
    return res;
  endfunction

  // Mostly short periods so that timers expire often; sometimes any 16-bit value.
  function automatic logic [etb_pkg::CountW-1:0] pick_period();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 80) return etb_pkg::CountW'($urandom_range(0, 12));
    if (roll < 95) return etb_pkg::CountW'($urandom_range(0, 300));
    return etb_pkg::CountW'($urandom);
  endfunction

  function automatic logic [etb_pkg::CmdW-1:0] pick_command();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 45) return etb_pkg::CMD_TICK;
    if (roll < 57) return etb_pkg::CMD_SET_PERIOD;
    if (roll < 69) return etb_pkg::CMD_READ_FLAG;
    if (roll < 77) return etb_pkg::CMD_CLEAR_FLAG;
    if (roll < 89) return etb_pkg::CMD_TAKE_FLAG;
    if (roll < 97) return etb_pkg::CMD_READ_TIME;
    if (roll < 99) return CMD_SPARE_LO;
    return CMD_SPARE_HI;
  endfunction

  // Offers one word, waits for it to be taken, then records what it should answer.
  task automatic send_word(input logic [etb_pkg::CmdW-1:0] cmd,
                           input logic [etb_pkg::IndexW-1:0] idx,
                           input logic [etb_pkg::CountW-1:0] period, input bit known,
                           input timer_result_t typed);
    timer_result_t predicted;
    int unsigned   gap;
    if (!quiet && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 4);
      repeat (gap) begin
        @(negedge clk_i);
        in_valid_i <= 1'b0;
      end
    end
    @(negedge clk_i);
    in_valid_i     <= 1'b1;
    command_i      <= cmd;
    timer_index_i  <= idx;
    period_value_i <= period;
    do @(posedge clk_i); while (in_stall_o);
    predicted = timer_bank_predict(cmd, idx, period);
    expected_results.push_back(known ? typed : predicted);
    words_sent++;
  endtask

  // Receiver stalls come in short bursts and stop for the quiet tail.
  initial begin : stall_driver
    int unsigned stall_left;
    stall_left  = 0;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (quiet) begin
        out_stall_i <= 1'b0;
      end else if (stall_left != 0) begin
        out_stall_i <= 1'b1;
        stall_left--;
      end else if ($urandom_range(0, 5) == 0) begin
        out_stall_i <= 1'b1;
        stall_left = $urandom_range(1, 4) - 1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin : result_check
    timer_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_results.size() == 0) begin
        $display("%0t: result word with none expected (flag %0d, time %0d)",
                 $time, flag_value_o, time_value_o);
        mismatches++;
      end else begin
        want = expected_results.pop_front();
        results_checked++;
        if (flag_value_o) flags_seen++;
        if (flag_value_o !== want.flag) begin
          $display("%0t: flag_value expected %0d actual %0d",
                   $time, want.flag, flag_value_o);
          mismatches++;
        end
        if (time_value_o !== want.ticks_div) begin
          $display("%0t: time_value expected %0d actual %0d",
                   $time, want.ticks_div, time_value_o);
          mismatches++;
        end
      end
    end
  end

  initial begin : watchdog
    int unsigned idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < StallLimit) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("%0t: no word moved for %0d cycles", $time, StallLimit);
    $display("event_timer_bank_top_tb failed");
    $finish;
  end

  initial begin : stimulus
    timer_result_t typed;
    rst_ni          = 1'b0;
    in_valid_i      = 1'b0;
    command_i       = etb_pkg::CMD_TICK;
    timer_index_i   = '0;
    period_value_i  = '0;
    quiet           = 1'b0;
    mismatches      = 0;
    words_sent      = 0;
    results_checked = 0;
    flags_seen      = 0;
    reset_timer_model();
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    for (int r = 0; r < DirectedLen; r++) begin
      typed.flag      = DirectedRows[r].flag;
      typed.ticks_div = DirectedRows[r].ticks_div;
      send_word(DirectedRows[r].cmd, DirectedRows[r].idx, DirectedRows[r].period,
                DirectedRows[r].known, typed);
    end

    typed = '0;
    for (int n = 0; n < RandomLen; n++) begin
      if (n >= RandomLen - QuietLen) quiet = 1'b1;
      send_word(pick_command(), etb_pkg::IndexW'($urandom_range(0, 7)), pick_period(),
                1'b0, typed);
    end
    @(negedge clk_i);
    in_valid_i <= 1'b0;

    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Sent %0d words; checked %0d results, %0d with a flag set, over %0d ticks.",
             words_sent, results_checked, flags_seen, tick_model);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("event_timer_bank_top_tb passed");
    end else begin
      $display("event_timer_bank_top_tb failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
